FILE: rtl/core/json_string_unescape_utf8_defines.svh
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication, disabled during reset
`define JSU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/jsu_pkg.sv
// types, constants and helper functions for the json string unescaper
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_PLAIN   = 3'd0,
        PH_ESC     = 3'd1,
        PH_HEX1    = 3'd2,
        PH_WANT_BS = 3'd3,
        PH_WANT_U  = 3'd4,
        PH_HEX2    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        FLT_DANGLING  = 3'd0,
        FLT_UNKNOWN   = 3'd1,
        FLT_BAD_HEX   = 3'd2,
        FLT_BAD_LOW   = 3'd3,
        FLT_TRUNCATED = 3'd4
    } fault_code_t;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // up to four utf-8 bytes, last_idx is the index of the final one
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } enc_t;

    // one queued group: all results caused by one input item
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            text_last;
        logic            fault;
        fault_code_t     code;
    } grp_t;

    // bit 4 is the valid flag, bits 3:0 the digit value
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic enc_t utf8_enc(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.last_idx = 2'd2;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.last_idx = 2'd3;
        end
        return e;
    endfunction

endpackage

FILE: rtl/core/json_string_unescape_utf8.sv
// output: result groups are registered in the group queue before reaching m_tdata
// throughput: one input item per cycle while s_tready is high; a multi-byte group
// drains one byte per cycle while m_tready is high, from a two-entry group queue; a
// full queue (multi-byte groups, m_tready low) stalls s_tready until the head drains
// reset: synchronous active-low aresetn empties the queue, clears the decode state
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // string_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast,   // text_last
    output logic [4:0] m_tuser    // run_last[0], fault[1], fault_code[4:2]
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hc_reg, hc_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  high_reg, high_next;
    logic        disc_reg, disc_next;

    grp_t        q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg;

    logic        s_acc;
    logic        push, pop;
    logic        err, emit;
    fault_code_t err_code;
    enc_t        enc;
    logic [4:0]  hx;
    logic [15:0] acc_shift;
    logic [20:0] cp_pair;
    grp_t        grp_new;
    grp_t        head;
    logic        run_last;

    assign s_tready = (cnt_reg != 2'd2);
    assign s_acc    = s_tvalid && s_tready;

    assign hx        = hex_val(s_tdata);
    assign acc_shift = {acc_reg[11:0], hx[3:0]};
    assign cp_pair   = SUPP_BASE + {1'b0, high_reg, acc_shift[9:0]};

    always_comb begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        acc_next   = acc_reg;
        high_next  = high_reg;
        disc_next  = disc_reg;
        err        = 1'b0;
        err_code   = FLT_DANGLING;
        emit       = 1'b0;
        enc        = '0;

        if (disc_reg) begin
            if (s_tlast) begin
                disc_next  = 1'b0;
                phase_next = PH_PLAIN;
                hc_next    = '0;
            end
        end else begin
            unique case (phase_reg)
                PH_ESC: begin
                    phase_next = PH_PLAIN;
                    emit       = 1'b1;
                    unique case (s_tdata)
                        CH_LOW_B:  enc.bytes[0] = 8'h08;
                        CH_LOW_F:  enc.bytes[0] = 8'h0C;
                        CH_LOW_N:  enc.bytes[0] = 8'h0A;
                        CH_LOW_R:  enc.bytes[0] = 8'h0D;
                        CH_LOW_T:  enc.bytes[0] = 8'h09;
                        CH_QUOTE:  enc.bytes[0] = CH_QUOTE;
                        CH_BSLASH: enc.bytes[0] = CH_BSLASH;
                        CH_LOW_U: begin
                            emit = 1'b0;
                            if (s_tlast) begin
                                err      = 1'b1;
                                err_code = FLT_TRUNCATED;
                            end else begin
                                phase_next = PH_HEX1;
                                hc_next    = '0;
                                acc_next   = '0;
                            end
                        end
                        default: begin
                            emit     = 1'b0;
                            err      = 1'b1;
                            err_code = FLT_UNKNOWN;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hx[4]) begin
                        err      = 1'b1;
                        err_code = FLT_BAD_HEX;
                    end else begin
                        acc_next = acc_shift;
                        if (hc_reg != 2'd3) begin
                            hc_next = hc_reg + 2'd1;
                            if (s_tlast) begin
                                err      = 1'b1;
                                err_code = FLT_TRUNCATED;
                            end
                        end else begin
                            hc_next = '0;
                            if (phase_reg == PH_HEX1) begin
                                if (acc_shift >= HIGH_SURR_MIN && acc_shift <= HIGH_SURR_MAX) begin
                                    high_next = acc_shift[9:0];
                                    if (s_tlast) begin
                                        err      = 1'b1;
                                        err_code = FLT_BAD_LOW;
                                    end else begin
                                        phase_next = PH_WANT_BS;
                                    end
                                end else begin
                                    enc        = utf8_enc({5'd0, acc_shift});
                                    emit       = 1'b1;
                                    phase_next = PH_PLAIN;
                                end
                            end else if (acc_shift >= LOW_SURR_MIN
                                         && acc_shift <= LOW_SURR_MAX) begin
                                enc        = utf8_enc(cp_pair);
                                emit       = 1'b1;
                                phase_next = PH_PLAIN;
                            end else begin
                                err      = 1'b1;
                                err_code = FLT_BAD_LOW;
                            end
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (s_tdata == CH_BSLASH) begin
                        if (s_tlast) begin
                            err      = 1'b1;
                            err_code = FLT_TRUNCATED;
                        end else begin
                            phase_next = PH_WANT_U;
                        end
                    end else begin
                        err      = 1'b1;
                        err_code = FLT_BAD_LOW;
                    end
                end
                PH_WANT_U: begin
                    if (s_tdata == CH_LOW_U) begin
                        if (s_tlast) begin
                            err      = 1'b1;
                            err_code = FLT_TRUNCATED;
                        end else begin
                            phase_next = PH_HEX2;
                            hc_next    = '0;
                            acc_next   = '0;
                        end
                    end else begin
                        err      = 1'b1;
                        err_code = FLT_BAD_LOW;
                    end
                end
                default: begin
                    phase_next = PH_PLAIN;
                    if (s_tdata == CH_BSLASH) begin
                        if (s_tlast) begin
                            err      = 1'b1;
                            err_code = FLT_DANGLING;
                        end else begin
                            phase_next = PH_ESC;
                        end
                    end else begin
                        enc.bytes[0] = s_tdata;
                        emit         = 1'b1;
                    end
                end
            endcase

            if (err) begin
                phase_next = PH_PLAIN;
                hc_next    = '0;
                disc_next  = !s_tlast;
            end else if (s_tlast) begin
                phase_next = PH_PLAIN;
                hc_next    = '0;
            end
        end
    end

    // an error result is a single zero byte that also closes the string
    always_comb begin
        grp_new.bytes     = err ? '0 : enc.bytes;
        grp_new.last_idx  = err ? 2'd0 : enc.last_idx;
        grp_new.text_last = err || s_tlast;
        grp_new.fault     = err;
        grp_new.code      = err ? err_code : FLT_DANGLING;
    end

    assign push = s_acc && !disc_reg && (err || emit);

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign run_last = (idx_reg == head.last_idx);
    assign m_tdata  = head.bytes[idx_reg];
    assign m_tlast  = run_last && head.text_last;
    assign m_tuser  = {head.code, head.fault, run_last};
    assign pop      = m_tvalid && m_tready && run_last;

    always_comb begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PLAIN;
            hc_reg     <= '0;
            acc_reg    <= '0;
            high_reg   <= '0;
            disc_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
        end else begin
            if (s_acc) begin
                phase_reg <= phase_next;
                hc_reg    <= hc_next;
                acc_reg   <= acc_next;
                high_reg  <= high_next;
                disc_reg  <= disc_next;
            end
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                idx_reg    <= '0;
            end else if (m_tvalid && m_tready) begin
                idx_reg <= idx_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // group queue payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= grp_new;
        end
    end

    `JSU_ASSERT_NOW(a_fault_closes, aclk, aresetn, m_tvalid && head.fault,
        run_last && m_tlast && idx_reg == 2'd0, "error item must be a single closing item")
    `JSU_ASSERT_NEXT(a_disc_quiet, aclk, aresetn, disc_reg && cnt_reg == 2'd0,
        cnt_reg == 2'd0, "queue grew while discarding")
    `JSU_ASSERT_NOW(a_idx_bound, aclk, aresetn, m_tvalid,
        idx_reg <= head.last_idx, "byte index ran past its group")

endmodule
